>>> design/euvt_pkg.sv
// shared types and constants of the encoder unwrap and velocity tracker
`default_nettype none

package euvt_pkg;

  localparam int unsigned COUNTS_PER_TURN_DEFAULT = 4096;
  localparam int unsigned SPEED_FRACTION_DEFAULT  = 8;

  localparam int ANGLE_W = 12;
  localparam int DT_W    = 16;
  localparam int POS_W   = 32;
  // 9 * speed + rate needs four guard bits plus one carry
  localparam int SUM_W   = POS_W + 5;
  localparam int SCALE_W = 20;

  localparam logic [SCALE_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [SUM_W-1:0]   AVG_DIVISOR  = 37'd10;
  // 0.8 in Q32, applied to the sum shifted right by three it gives a tenth
  localparam logic [POS_W-1:0]   TENTH_RECIP  = 32'hCCCC_CCCD;

  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_REVERSE = 2'd0;

  typedef struct packed {
    logic capture;
    logic classify;
    logic apply_simple;
    logic multiply;
    logic div_load_rate;
    logic avg_mul;
    logic div_step;
    logic rate_sat;
    logic sum;
    logic avg_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

>>> design/euvt_div.sv
// restoring divider, one quotient bit per cycle while step_i is high
`default_nettype none

module euvt_div #(
  parameter int DIV_W = 41
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic                        step_i,
  input  wire logic [DIV_W-1:0]            dividend_i,
  input  wire logic [euvt_pkg::DT_W-1:0]   divisor_i,
  output logic      [DIV_W-1:0]            quotient_o,
  output logic                             last_o
);
  import euvt_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DT_W-1:0]  rem_q, rem_d;
  logic [DT_W-1:0]  dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DT_W:0]    trial;
  logic [DT_W:0]    diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? diff[DT_W-1:0] : trial[DT_W-1:0];
    quo_d = {quo_q[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign last_o     = cnt_q == CNT_W'(DIV_W - 1);

endmodule

`default_nettype wire

>>> design/euvt_dp.sv
// datapath: unwrap, position accumulator, rate and filtered velocity
`default_nettype none

module euvt_dp #(
  parameter int unsigned COUNTS_PER_TURN     = euvt_pkg::COUNTS_PER_TURN_DEFAULT,
  parameter int unsigned SPEED_FRACTION_BITS = euvt_pkg::SPEED_FRACTION_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire euvt_pkg::cmd_t                    cmd_i,
  output euvt_pkg::status_t                      status_o,
  input  wire logic                              kind_i,
  input  wire logic [euvt_pkg::ANGLE_W-1:0]      raw_angle_i,
  input  wire logic [euvt_pkg::DT_W-1:0]         dt_us_i,
  input  wire logic                              reverse_i,
  output logic signed [euvt_pkg::POS_W-1:0]      directed_position_o,
  output logic signed [euvt_pkg::POS_W-1:0]      directed_velocity_o,
  output logic                                   tracking_o
);
  import euvt_pkg::*;

  localparam int CLOG_C     = $clog2(COUNTS_PER_TURN);
  localparam int MAG_W      = (CLOG_C + 1 > ANGLE_W) ? CLOG_C + 1 : ANGLE_W;
  localparam int DELTA_W    = MAG_W + 1;
  localparam int PROD_W     = MAG_W + SCALE_W;
  localparam int RATE_NUM_W = PROD_W + SPEED_FRACTION_BITS;
  localparam int DIV_W      = RATE_NUM_W;

  localparam logic signed [DELTA_W-1:0] TURN = DELTA_W'(COUNTS_PER_TURN);
  localparam logic signed [DELTA_W-1:0] HALF = DELTA_W'(COUNTS_PER_TURN / 2);
  localparam logic [POS_W-1:0] DEADBAND = POS_W'(64'd1 << SPEED_FRACTION_BITS);

  // tracker state
  logic [ANGLE_W-1:0]      last_angle_q;
  logic [POS_W-1:0]        turn_pos_q;
  logic signed [POS_W-1:0] speed_q;
  logic                    started_q;

  // per-item working registers
  logic                      kind_q;
  logic [ANGLE_W-1:0]        raw_q;
  logic [DT_W-1:0]           dt_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic                      neg_q;
  logic [PROD_W-1:0]         prod_q;
  logic signed [POS_W-1:0]   rate_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [POS_W-1:0]          avg_est_q;

  logic signed [DELTA_W-1:0] diff;
  logic signed [DELTA_W-1:0] delta_wrap;
  logic [DELTA_W-1:0]        mag_ext;
  logic [MAG_W-1:0]          mag;
  logic [PROD_W-1:0]         prod_d;
  logic [DIV_W-1:0]          quotient;
  logic                      div_last;
  logic                      quo_high;
  logic signed [POS_W-1:0]   rate_d;
  logic signed [SUM_W-1:0]   speed_ext;
  logic signed [SUM_W-1:0]   rate_ext;
  logic signed [SUM_W-1:0]   sum_d;
  logic [SUM_W-1:0]          sum_mag;
  logic [POS_W-1:0]          avg_in;
  logic [2*POS_W-1:0]        avg_prod;
  logic [SUM_W-1:0]          avg_back;
  logic [SUM_W-1:0]          avg_rem;
  logic [POS_W-1:0]          avg_val;
  logic signed [POS_W-1:0]   speed_d;
  logic [DIV_W-1:0]          div_dividend;

  always_comb begin
    diff = $signed({{(DELTA_W - ANGLE_W){1'b0}}, raw_q})
         - $signed({{(DELTA_W - ANGLE_W){1'b0}}, last_angle_q});
    if (diff > HALF) begin
      delta_wrap = diff - TURN;
    end else if (diff < -HALF) begin
      delta_wrap = diff + TURN;
    end else begin
      delta_wrap = diff;
    end
  end

  always_comb begin
    mag_ext = delta_q[DELTA_W-1] ? DELTA_W'(-delta_q) : DELTA_W'(delta_q);
    mag     = mag_ext[MAG_W-1:0];
    prod_d  = {{SCALE_W{1'b0}}, mag} * {{MAG_W{1'b0}}, USEC_PER_SEC};
  end

  // saturate the rate quotient to the signed 32-bit range
  always_comb begin
    quo_high = |quotient[DIV_W-1:POS_W-1];
    if (quo_high) begin
      rate_d = neg_q ? $signed({1'b1, {(POS_W-1){1'b0}}}) : $signed({1'b0, {(POS_W-1){1'b1}}});
    end else begin
      rate_d = neg_q ? -$signed(quotient[POS_W-1:0]) : $signed(quotient[POS_W-1:0]);
    end
  end

  always_comb begin
    speed_ext = $signed({{(SUM_W - POS_W){speed_q[POS_W-1]}}, speed_q});
    rate_ext  = $signed({{(SUM_W - POS_W){rate_q[POS_W-1]}}, rate_q});
    sum_d     = (speed_ext <<< 3) + speed_ext + rate_ext;
    sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  end

  // divide by ten: estimate from the reciprocal, then at most one step up
  always_comb begin
    // the magnitude never exceeds ten times 2^31, so bits above 34 are clear
    avg_in   = sum_mag[POS_W+2:3];
    avg_prod = {{POS_W{1'b0}}, avg_in} * {{POS_W{1'b0}}, TENTH_RECIP};
    avg_back = SUM_W'({avg_est_q, 3'b000}) + SUM_W'({avg_est_q, 1'b0});
    avg_rem  = sum_mag - avg_back;
    avg_val  = avg_est_q + POS_W'(avg_rem >= AVG_DIVISOR);
  end

  // magnitude below one count per second is forced to zero
  always_comb begin
    if (avg_val < DEADBAND) begin
      speed_d = '0;
    end else begin
      speed_d = sum_q[SUM_W-1] ? -$signed(avg_val) : $signed(avg_val);
    end
  end

  always_comb begin
    div_dividend = DIV_W'(prod_q) << SPEED_FRACTION_BITS;
  end

  euvt_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.div_load_rate),
    .step_i     (cmd_i.div_step),
    .dividend_i (div_dividend),
    .divisor_i  (dt_q),
    .quotient_o (quotient),
    .last_o     (div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_angle_q <= '0;
      turn_pos_q   <= '0;
      speed_q      <= '0;
      started_q    <= 1'b0;
    end else begin
      if (cmd_i.apply_simple) begin
        if (kind_q) begin
          turn_pos_q <= '0;
        end else if (dt_q != '0) begin
          last_angle_q <= raw_q;
          turn_pos_q   <= '0;
          speed_q      <= '0;
          started_q    <= 1'b1;
        end
      end
      if (cmd_i.multiply) begin
        last_angle_q <= raw_q;
        turn_pos_q   <= turn_pos_q + {{(POS_W - DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
      end
      if (cmd_i.avg_done) begin
        speed_q <= speed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      raw_q  <= raw_angle_i;
      dt_q   <= dt_us_i;
    end
    if (cmd_i.classify) begin
      delta_q <= delta_wrap;
    end
    if (cmd_i.multiply) begin
      prod_q <= prod_d;
      neg_q  <= delta_q[DELTA_W-1];
    end
    if (cmd_i.rate_sat) begin
      rate_q <= rate_d;
    end
    if (cmd_i.sum) begin
      sum_q <= sum_d;
    end
    if (cmd_i.avg_mul) begin
      avg_est_q <= avg_prod[2*POS_W-1:POS_W];
    end
    if (cmd_i.out_load) begin
      directed_position_o <= reverse_i ? -$signed(turn_pos_q) : $signed(turn_pos_q);
      directed_velocity_o <= reverse_i ? -speed_q : speed_q;
      tracking_o          <= started_q;
    end
  end

  assign status_o.skip     = kind_q | (dt_q == '0) | ~started_q;
  assign status_o.div_last = div_last;

endmodule

`default_nettype wire

>>> design/euvt_ctrl.sv
// controller: sequences one item through the datapath
`default_nettype none

module euvt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire euvt_pkg::status_t status_i,
  output euvt_pkg::cmd_t         cmd_o
);
  import euvt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_MULT,
    ST_RATE_LOAD,
    ST_RATE_DIV,
    ST_RATE_SAT,
    ST_SUM,
    ST_AVG_MUL,
    ST_AVG_DONE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        if (status_i.skip) begin
          cmd_o.apply_simple = 1'b1;
          state_d            = ST_FINISH;
        end else begin
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.multiply = 1'b1;
        state_d        = ST_RATE_LOAD;
      end
      ST_RATE_LOAD: begin
        cmd_o.div_load_rate = 1'b1;
        state_d             = ST_RATE_DIV;
      end
      ST_RATE_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_RATE_SAT;
        end
      end
      ST_RATE_SAT: begin
        cmd_o.rate_sat = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_AVG_MUL;
      end
      ST_AVG_MUL: begin
        cmd_o.avg_mul = 1'b1;
        state_d       = ST_AVG_DONE;
      end
      ST_AVG_DONE: begin
        cmd_o.avg_done = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here while the previous result is still unclaimed
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> design/encoder_unwrap_velocity_tracker.sv
// top level of the encoder unwrap and velocity tracker
//
// Input channel (in_valid_i / in_ready_o) takes one item: kind_i, raw_angle_i
// and dt_us_i. Every item gives exactly one result on the output channel
// (out_valid_o / out_ready_i): directed_position_o, directed_velocity_o and
// tracking_o. The reverse_direction register sits at byte address 0 of the
// APB port; pready is always high and reads return the register.
// A zero command, a zero interval or the first sample goes straight from
// classify to finish; a tracked sample also passes through the multiply, the
// restoring divider of width DIV_W = MAG_W + 20 + SPEED_FRACTION_BITS that
// forms the rate (one bit a cycle), saturation and the filter. The divide by
// ten is a reciprocal multiply and one correction. At the defaults DIV_W = 41.
// One item is in work at a time; in_ready_o returns high when the result is
// moved into the output register, so the next item is taken while that result
// waits. If the receiver stalls with a result still held, the next finished
// result waits inside the block. Reset clears position, velocity, the tracking
// flag, the last angle and reverse_direction, and leaves no result pending.
`default_nettype none

module encoder_unwrap_velocity_tracker #(
  parameter int unsigned COUNTS_PER_TURN     = euvt_pkg::COUNTS_PER_TURN_DEFAULT,
  parameter int unsigned SPEED_FRACTION_BITS = euvt_pkg::SPEED_FRACTION_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                kind_i,
  input  wire logic [euvt_pkg::ANGLE_W-1:0]        raw_angle_i,
  input  wire logic [euvt_pkg::DT_W-1:0]           dt_us_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [euvt_pkg::POS_W-1:0]        directed_position_o,
  output logic signed [euvt_pkg::POS_W-1:0]        directed_velocity_o,
  output logic                                     tracking_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [euvt_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import euvt_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    reverse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_REVERSE)) begin
      reverse_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_REVERSE) ? {31'b0, reverse_q} : 32'b0;

  euvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  euvt_dp #(
    .COUNTS_PER_TURN     (COUNTS_PER_TURN),
    .SPEED_FRACTION_BITS (SPEED_FRACTION_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .kind_i              (kind_i),
    .raw_angle_i         (raw_angle_i),
    .dt_us_i             (dt_us_i),
    .reverse_i           (reverse_q),
    .directed_position_o (directed_position_o),
    .directed_velocity_o (directed_velocity_o),
    .tracking_o          (tracking_o)
  );

endmodule

`default_nettype wire

>>> design/euvt_checker.sv
// port-level checks of the tracker, bound to the top level
`default_nettype none

module euvt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] directed_position_o,
  input wire logic [31:0] directed_velocity_o,
  input wire logic        tracking_o,
  input wire logic        pready
);

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(directed_position_o)
      && $stable(directed_velocity_o) && $stable(tracking_o)))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while previous one in work");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  // leaving reset: no stale result, ready for an item
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (!out_valid_o && in_ready_o))
    else $error("block not clean after reset");

endmodule

bind encoder_unwrap_velocity_tracker euvt_checker u_euvt_checker (.*);

`default_nettype wire

>>> tb/euvt_track_checker.sv
// scoreboard that predicts and checks every result of the encoder unwrap tracker
`timescale 1ns / 1ps

package euvt_tb_pkg;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_ZERO   = 1'b1
  } item_kind_e;

endpackage

module euvt_track_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              kind_i,
  input  logic [euvt_pkg::ANGLE_W-1:0]      raw_angle_i,
  input  logic [euvt_pkg::DT_W-1:0]         dt_us_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [euvt_pkg::POS_W-1:0] directed_position_i,
  input  logic signed [euvt_pkg::POS_W-1:0] directed_velocity_i,
  input  logic                              tracking_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [euvt_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  input  logic                              pready,
  output int                                readings_owed_o,
  output int                                readings_seen_o,
  output int                                mismatch_count_o
);
  import euvt_pkg::*;
  import euvt_tb_pkg::*;

  localparam int TURN_COUNTS = int'(COUNTS_PER_TURN_DEFAULT);
  localparam int HALF_TURN   = TURN_COUNTS / 2;
  localparam int FRAC_BITS   = int'(SPEED_FRACTION_DEFAULT);
  localparam longint UNIT_SPEED = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] velocity;
    logic             tracking;
  } reading_t;

  // predictor state
  logic [ANGLE_W-1:0] prev_angle;
  logic [POS_W-1:0]   turn_count;
  int                 speed_q;
  logic               locked;
  logic               reversed;

  reading_t expected_readings[$];

  initial begin
    readings_owed_o  = 0;
    readings_seen_o  = 0;
    mismatch_count_o = 0;
  end

  function automatic reading_t predict_reading(logic kind, logic [ANGLE_W-1:0] raw,
                                               logic [DT_W-1:0] dt);
    int delta;
    int now_angle;
    int old_angle;
    longint unsigned mag;
    longint unsigned quot;
    longint rate;
    longint acc;
    reading_t r;
    if (kind == KIND_ZERO) begin
      turn_count = '0;
    end else if (dt != '0) begin
      if (!locked) begin
        prev_angle = raw;
        turn_count = '0;
        speed_q    = 0;
        locked     = 1'b1;
      end else begin
        now_angle = int'(raw);
        old_angle = int'(prev_angle);
        delta = now_angle - old_angle;
        if (delta > HALF_TURN) delta -= TURN_COUNTS;
        else if (delta < -HALF_TURN) delta += TURN_COUNTS;
        prev_angle = raw;
        turn_count = turn_count + POS_W'(delta);
        mag  = (delta < 0) ? longint'(-delta) : longint'(delta);
        quot = ((mag * 64'd1000000) << FRAC_BITS) / 64'(dt);
        if (delta < 0) begin
          rate = (quot >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(quot);
        end else begin
          rate = (quot > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(quot);
        end
        acc = (9 * longint'(speed_q) + rate) / 10;
        // anything slower than one count per second reads as standstill
        if (acc < UNIT_SPEED && acc > -UNIT_SPEED) acc = 0;
        speed_q = int'(acc);
      end
    end
    r.position = reversed ? (32'd0 - turn_count) : turn_count;
    r.velocity = reversed ? (32'd0 - POS_W'(speed_q)) : POS_W'(speed_q);
    r.tracking = locked;
    return r;
  endfunction

  function automatic void compare_field(string name, logic signed [POS_W-1:0] want,
                                        logic signed [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      prev_angle = '0;
      turn_count = '0;
      speed_q    = 0;
      locked     = 1'b0;
      reversed   = 1'b0;
      expected_readings.delete();
      readings_owed_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        readings_seen_o++;
        if (expected_readings.size() == 0) begin
          $error("unexpected result: position %0d, velocity %0d, tracking %0b",
                 directed_position_i, directed_velocity_i, tracking_i);
          mismatch_count_o++;
        end else begin
          want = expected_readings.pop_front();
          compare_field("directed_position", want.position, directed_position_i);
          compare_field("directed_velocity", want.velocity, directed_velocity_i);
          compare_field("tracking", {31'd0, want.tracking}, {31'd0, tracking_i});
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_readings.push_back(predict_reading(kind_i, raw_angle_i, dt_us_i));
      end
      if (psel && penable && pwrite && pready && paddr == REG_REVERSE) begin
        reversed = pwdata[0];
      end
      readings_owed_o <= expected_readings.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// stimulus and verdict for the encoder unwrap and velocity tracker
`timescale 1ns / 1ps

module tb_top;
  import euvt_pkg::*;
  import euvt_tb_pkg::*;

  localparam int LIMIT_CYCLES     = 1_000_000;
  localparam int RANDOM_PER_PHASE = 400;
  localparam int SETTLE_CYCLES    = 200;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               kind      = KIND_SAMPLE;
  logic [ANGLE_W-1:0] raw_angle = '0;
  logic [DT_W-1:0]    dt_us     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [POS_W-1:0] position;
  logic signed [POS_W-1:0] velocity;
  logic               tracking;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  int readings_owed;
  int readings_seen;
  int mismatches;
  int cycle_cnt   = 0;
  int sent_items  = 0;
  int directed_items;
  logic calm      = 1'b0;
  int cur_angle   = 0;
  int drift       = 0;

  always #2 clk = ~clk;

  encoder_unwrap_velocity_tracker DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .kind_i             (kind),
    .raw_angle_i        (raw_angle),
    .dt_us_i            (dt_us),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .directed_position_o(position),
    .directed_velocity_o(velocity),
    .tracking_o         (tracking),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  euvt_track_checker tracker_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .kind_i             (kind),
    .raw_angle_i        (raw_angle),
    .dt_us_i            (dt_us),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .directed_position_i(position),
    .directed_velocity_i(velocity),
    .tracking_i         (tracking),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .readings_owed_o    (readings_owed),
    .readings_seen_o    (readings_seen),
    .mismatch_count_o   (mismatches)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 22);
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(item_kind_e k, logic [ANGLE_W-1:0] raw, logic [DT_W-1:0] dt);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    raw_angle <= raw;
    dt_us     <= dt;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (k == KIND_SAMPLE && dt != '0) cur_angle = int'(raw);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reverse(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_REVERSE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count, bit with_calm, bit with_pause);
    int mode;
    logic [ANGLE_W-1:0] raw;
    logic [DT_W-1:0] dt;
    for (int i = 0; i < count; i++) begin
      if (with_calm) calm = (i >= count / 4) && (i < count / 2);
      if (with_pause && i == (3 * count) / 4) drain_results();
      if (i % 20 == 0) drift = int'($urandom_range(600)) - 300;
      mode = int'($urandom_range(99));
      if (mode < 50) begin
        // steady rotation so the velocity filter settles
        raw = ANGLE_W'(cur_angle + drift);
        dt  = DT_W'($urandom_range(4000, 200));
        send_item(KIND_SAMPLE, raw, dt);
      end else if (mode < 65) begin
        send_item(KIND_SAMPLE, ANGLE_W'($urandom_range(4095)),
                  DT_W'($urandom_range(65535, 1)));
      end else if (mode < 75) begin
        // right around half a turn either way
        raw = ANGLE_W'(cur_angle + ($urandom_range(1) ? 1 : -1) * $urandom_range(2049, 2047));
        send_item(KIND_SAMPLE, raw, DT_W'($urandom_range(65535, 1)));
      end else if (mode < 83) begin
        send_item(KIND_SAMPLE, ANGLE_W'($urandom_range(4095)), DT_W'($urandom_range(20, 1)));
      end else if (mode < 90) begin
        send_item(KIND_SAMPLE, ANGLE_W'($urandom_range(4095)), '0);
      end else if (mode < 95) begin
        send_item(KIND_ZERO, ANGLE_W'($urandom_range(4095)), DT_W'($urandom_range(65535)));
      end else begin
        send_item(item_kind_e'($urandom_range(1)), ANGLE_W'($urandom_range(4095)),
                  DT_W'($urandom_range(65535)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reverse(32'hFFFF_FFFE);

    // directed: before tracking, first latch, wraps, saturation, standstill
    send_item(KIND_ZERO,   12'hFFF, 16'hFFFF);
    send_item(KIND_SAMPLE, 12'd123, 16'd0);
    send_item(KIND_SAMPLE, 12'hFFF, 16'hFFFF);
    send_item(KIND_SAMPLE, 12'd0,   16'hFFFF);
    repeat (5) send_item(KIND_SAMPLE, 12'd0, 16'd1000);
    send_item(KIND_SAMPLE, 12'd2048, 16'd1000);
    send_item(KIND_SAMPLE, 12'd0,    16'd1000);
    send_item(KIND_SAMPLE, 12'd2049, 16'd1);
    send_item(KIND_SAMPLE, 12'd0,    16'd1);
    send_item(KIND_SAMPLE, 12'd2047, 16'd1);
    send_item(KIND_SAMPLE, 12'd0,    16'd1);
    send_item(KIND_SAMPLE, 12'hFFF,  16'd0);
    send_item(KIND_ZERO,   12'd0,    16'd0);
    send_item(KIND_SAMPLE, 12'hAAA,  16'h5555);
    send_item(KIND_SAMPLE, 12'h555,  16'hAAAA);
    send_item(KIND_SAMPLE, 12'hFFF,  16'hFFFF);
    directed_items = sent_items;

    drain_results();
    write_reverse(32'h0000_0001);
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b1);

    drain_results();
    write_reverse(32'h0000_0000);
    run_random(RANDOM_PER_PHASE, 1'b1, 1'b0);

    drain_results();
    write_reverse(32'hFFFF_FFFF);
    run_random(RANDOM_PER_PHASE, 1'b0, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d directed) over %0d cycles, %0d results compared",
             sent_items, directed_items, cycle_cnt, readings_seen);
    $display("both directions, half-turn wraps, rate saturation, zero intervals, zero commands");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/euvt_pkg.sv
design/euvt_div.sv
design/euvt_dp.sv
design/euvt_ctrl.sv
design/encoder_unwrap_velocity_tracker.sv
design/euvt_checker.sv
tb/euvt_track_checker.sv
tb/tb_top.sv
